>>> rtl/core/wbt_pkg.sv
`default_nettype none
package wbt_pkg;

  localparam int unsigned TableSize = 32;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned PhaseW    = 16;
  localparam int unsigned WarpW     = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned EventW    = 8;
  localparam int unsigned WidW      = 3;
  localparam int unsigned ErrW      = 2;

  typedef enum logic [2:0] {
    OP_READ_PHASE = 3'd0,
    OP_ARRIVE     = 3'd1,
    OP_WAIT       = 3'd2,
    OP_GLOBAL_RES = 3'd3,
    OP_EV_ATTACH  = 3'd4,
    OP_EV_RELEASE = 3'd5
  } opcode_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_ZERO_CNT  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [WarpW-1:0]  wmask;
    logic [CountW-1:0] count;
    logic [EventW-1:0] events;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]        opcode;
    logic [IdxW-1:0]   slot_idx;
    logic              glob_sel;
    logic [CountW-1:0] arrival_count;
    logic [WidW-1:0]   warp_id;
    logic              sync_flag;
    logic [PhaseW-1:0] expected_phase;
    logic [WarpW-1:0]  active_mask;
  } req_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase_value;
    logic              must_wait;
    logic [WarpW-1:0]  resume_mask;
    logic              notify_global;
    logic [CountW-1:0] notify_count;
    err_e              error_code;
  } res_t;

  function automatic logic [3:0] popcount8(input logic [WarpW-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WarpW; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/wbt_ram.sv
`default_nettype none
module wbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/warp_barrier_table.sv
`default_nettype none
// Table of 32 warp barriers kept in one synchronous RAM. Each transaction reads its
// entry, updates it and writes it back, and returns exactly one result transaction.
// An operation reads the RAM entry, then updates it and loads the output register. A
// new transaction is taken only after the last one is written back, and the write-back
// waits while the output register is full. A local arrive whose new count is at least
// twice the arrival count needs a remainder from the bit-serial divider. Entries never
// written read as zero, so the block works right after reset with no clearing.
module warp_barrier_table
  import wbt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [IdxW-1:0]   slot_idx_i,
  input  wire logic              glob_sel_i,
  input  wire logic [CountW-1:0] arrival_count_i,
  input  wire logic [WidW-1:0]   warp_id_i,
  input  wire logic              sync_flag_i,
  input  wire logic [PhaseW-1:0] expected_phase_i,
  input  wire logic [WarpW-1:0]  active_mask_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [PhaseW-1:0] phase_value_o,
  output logic                   must_wait_o,
  output logic      [WarpW-1:0]  resume_mask_o,
  output logic                   notify_global_o,
  output logic      [CountW-1:0] notify_count_o,
  output logic      [ErrW-1:0]   error_code_o
);

  state_e state_q, state_d;
  logic [TableSize-1:0] valid_q;
  logic hit_q;
  req_t req_q;
  logic out_valid_q;
  res_t out_q;
  entry_t stash_ent_q;
  res_t stash_res_q;
  logic [CountW:0] num_q;
  logic [CountW-1:0] rem_q, rem_d;
  logic [3:0] dcnt_q;

  logic accept, slot_free;
  logic ram_we;
  entry_t ram_wdata, ram_rdata, cur, nxt, fin_ent;
  res_t res;
  logic need_div;
  logic [CountW:0] next9, diff9, shift9;
  logic [WarpW-1:0] wbit, wm_set;
  logic [EventW-1:0] ev_dec;
  logic fin_out, exec_out, div_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  wbt_ram #(
    .Width(EntryW),
    .Depth(TableSize)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(req_q.slot_idx),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(slot_idx_i),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    cur = hit_q ? ram_rdata : '0;
    nxt = cur;
    res = '0;
    res.error_code = ERR_NONE;
    need_div = 1'b0;
    wbit = WarpW'(1) << req_q.warp_id;
    wm_set = cur.wmask | wbit;
    next9 = {1'b0, cur.count} + 9'd1;
    diff9 = next9 - {1'b0, req_q.arrival_count};
    ev_dec = cur.events - 8'd1;
    unique case (req_q.opcode)
      OP_ARRIVE: begin
        if (req_q.glob_sel) begin
          nxt.count = req_q.arrival_count;
          nxt.wmask = wm_set;
          if (popcount8(wm_set) == popcount8(req_q.active_mask) && cur.events == '0) begin
            res.notify_global = 1'b1;
            res.notify_count = req_q.arrival_count;
            nxt.wmask = '0;
            nxt.count = '0;
          end
        end else if (req_q.arrival_count == '0) begin
          res.error_code = ERR_ZERO_CNT;
        end else begin
          if (req_q.sync_flag) begin
            nxt.wmask = wm_set;
          end
          if (next9 == {1'b0, req_q.arrival_count} && cur.events == '0) begin
            res.resume_mask = nxt.wmask;
            nxt.wmask = '0;
            nxt.phase = cur.phase + 16'd1;
          end
          if (next9 < {1'b0, req_q.arrival_count}) begin
            nxt.count = next9[CountW-1:0];
          end else if (diff9 < {1'b0, req_q.arrival_count}) begin
            nxt.count = diff9[CountW-1:0];
          end else begin
            need_div = 1'b1;
          end
        end
      end
      OP_WAIT: begin
        if (cur.phase == req_q.expected_phase) begin
          res.must_wait = 1'b1;
          nxt.wmask = wm_set;
        end
      end
      OP_GLOBAL_RES: begin
        res.resume_mask = req_q.active_mask;
        nxt.wmask = '0;
        nxt.phase = cur.phase + 16'd1;
      end
      OP_EV_ATTACH: begin
        if (cur.events == '1) begin
          res.error_code = ERR_OVERFLOW;
        end else begin
          nxt.events = cur.events + 8'd1;
        end
      end
      OP_EV_RELEASE: begin
        if (cur.events == '0) begin
          res.error_code = ERR_UNDERFLOW;
        end else begin
          nxt.events = ev_dec;
          if (ev_dec == '0) begin
            if (req_q.glob_sel) begin
              if (popcount8(cur.wmask) == popcount8(req_q.active_mask)) begin
                res.notify_global = 1'b1;
                res.notify_count = cur.count;
                nxt.wmask = '0;
                nxt.count = '0;
              end
            end else if (cur.count == '0) begin
              res.resume_mask = cur.wmask;
              nxt.wmask = '0;
              nxt.phase = cur.phase + 16'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.phase_value = nxt.phase;
  end

  assign shift9 = {rem_q, num_q[CountW]};
  always_comb begin
    if (shift9 >= {1'b0, req_q.arrival_count}) begin
      rem_d = CountW'(shift9 - {1'b0, req_q.arrival_count});
    end else begin
      rem_d = shift9[CountW-1:0];
    end
  end
  assign div_last = (dcnt_q == 4'd8);

  always_comb begin
    fin_ent = stash_ent_q;
    fin_ent.count = rem_q;
  end

  always_comb begin
    state_d = state_q;
    exec_out = 1'b0;
    fin_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (need_div) begin
          state_d = S_DIV;
        end else if (slot_free) begin
          exec_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          fin_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_we = exec_out || fin_out;
  assign ram_wdata = fin_out ? fin_ent : nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[req_q.slot_idx] <= 1'b1;
      end
      if (ram_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        dcnt_q <= '0;
      end else if (state_q == S_DIV) begin
        dcnt_q <= dcnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q <= valid_q[slot_idx_i];
      req_q.opcode <= opcode_i;
      req_q.slot_idx <= slot_idx_i;
      req_q.glob_sel <= glob_sel_i;
      req_q.arrival_count <= arrival_count_i;
      req_q.warp_id <= warp_id_i;
      req_q.sync_flag <= sync_flag_i;
      req_q.expected_phase <= expected_phase_i;
      req_q.active_mask <= active_mask_i;
    end
    if (state_q == S_EXEC) begin
      stash_ent_q <= nxt;
      stash_res_q <= res;
      num_q <= next9;
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
    end
    if (exec_out) begin
      out_q <= res;
    end else if (fin_out) begin
      out_q <= stash_res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_value_o = out_q.phase_value;
  assign must_wait_o = out_q.must_wait;
  assign resume_mask_o = out_q.resume_mask;
  assign notify_global_o = out_q.notify_global;
  assign notify_count_o = out_q.notify_count;
  assign error_code_o = out_q.error_code;

`ifndef SYNTH
  a_resume_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && resume_mask_o != '0) |-> (error_code_o == ERR_NONE))
    else $error("resume mask given with an error code");

  a_notify_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !notify_global_o) |-> (notify_count_o == '0))
    else $error("core count sent without a global notification");

  a_wait_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && must_wait_o) |-> (resume_mask_o == '0 && !notify_global_o))
    else $error("wait result also resumes or notifies");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC || state_q == S_FIN))
    else $error("entry written outside of an update");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dcnt_q <= 4'd8))
    else $error("remainder step count out of range");
`endif

endmodule
`default_nettype wire

>>> verif/tb_warp_barrier_table.sv
`timescale 1ns / 100ps
module tb_warp_barrier_table;
  import wbt_pkg::*;

  localparam logic [2:0] OpUnusedLo = 3'd6;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned RandomItems = 460;
  localparam int unsigned FloodEntry  = 29;

  class barrier_scoreboard;
    logic [PhaseW-1:0] phase_tab[TableSize];
    logic [WarpW-1:0]  wmask_tab[TableSize];
    logic [CountW-1:0] count_tab[TableSize];
    logic [EventW-1:0] event_tab[TableSize];
    res_t expected_q[$];
    int errors;
    int checked;
    int resumes;
    int notifies;
    int faults;

    function new();
      for (int i = 0; i < TableSize; i++) begin
        phase_tab[i] = '0;
        wmask_tab[i] = '0;
        count_tab[i] = '0;
        event_tab[i] = '0;
      end
      errors = 0;
      checked = 0;
      resumes = 0;
      notifies = 0;
      faults = 0;
    endfunction

    function logic [PhaseW-1:0] phase_of(int idx);
      return phase_tab[idx];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [WarpW-1:0] release_local(int e);
      logic [WarpW-1:0] m;
      m = wmask_tab[e];
      wmask_tab[e] = '0;
      phase_tab[e] = phase_tab[e] + 1'b1;
      return m;
    endfunction

    function void note_request(req_t r);
      res_t x;
      int e;
      int nxt;
      logic [WarpW-1:0] wbit;
      logic [WarpW-1:0] act;
      x = '0;
      x.error_code = ERR_NONE;
      e = int'(r.slot_idx);
      wbit = WarpW'(1) << r.warp_id;
      act = r.active_mask;
      case (r.opcode)
        OP_ARRIVE: begin
          if (r.glob_sel) begin
            count_tab[e] = r.arrival_count;
            wmask_tab[e] |= wbit;
            if ($countones(wmask_tab[e]) == $countones(act) && event_tab[e] == '0) begin
              x.notify_global = 1'b1;
              x.notify_count = r.arrival_count;
              wmask_tab[e] = '0;
              count_tab[e] = '0;
              event_tab[e] = '0;
            end
          end else if (r.arrival_count == '0) begin
            x.error_code = ERR_ZERO_CNT;
          end else begin
            nxt = int'(count_tab[e]) + 1;
            if (r.sync_flag) wmask_tab[e] |= wbit;
            if (nxt == int'(r.arrival_count) && event_tab[e] == '0) begin
              x.resume_mask = release_local(e);
            end
            count_tab[e] = CountW'(nxt % int'(r.arrival_count));
          end
        end
        OP_WAIT: begin
          if (phase_tab[e] == r.expected_phase) begin
            x.must_wait = 1'b1;
            wmask_tab[e] |= wbit;
          end
        end
        OP_GLOBAL_RES: begin
          x.resume_mask = act;
          wmask_tab[e] = '0;
          phase_tab[e] = phase_tab[e] + 1'b1;
        end
        OP_EV_ATTACH: begin
          if (event_tab[e] == '1) x.error_code = ERR_OVERFLOW;
          else event_tab[e] = event_tab[e] + 1'b1;
        end
        OP_EV_RELEASE: begin
          if (event_tab[e] == '0) begin
            x.error_code = ERR_UNDERFLOW;
          end else begin
            event_tab[e] = event_tab[e] - 1'b1;
            if (event_tab[e] == '0) begin
              if (r.glob_sel) begin
                if ($countones(wmask_tab[e]) == $countones(act)) begin
                  x.notify_global = 1'b1;
                  x.notify_count = count_tab[e];
                  wmask_tab[e] = '0;
                  count_tab[e] = '0;
                end
              end else if (count_tab[e] == '0) begin
                x.resume_mask = release_local(e);
              end
            end
          end
        end
        default: begin
        end
      endcase
      x.phase_value = phase_tab[e];
      if (x.resume_mask != '0) resumes++;
      if (x.notify_global) notifies++;
      if (x.error_code != ERR_NONE) faults++;
      expected_q.push_back(x);
    endfunction

    task report(string msg);
      $display("MISMATCH at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t x;
      if (expected_q.size() == 0) begin
        report("result transaction with no request outstanding");
        checked++;
        return;
      end
      x = expected_q.pop_front();
      if (got.phase_value !== x.phase_value)
        report($sformatf("phase_value %h, expected %h", got.phase_value, x.phase_value));
      if (got.must_wait !== x.must_wait)
        report($sformatf("must_wait %b, expected %b", got.must_wait, x.must_wait));
      if (got.resume_mask !== x.resume_mask)
        report($sformatf("resume_mask %h, expected %h", got.resume_mask, x.resume_mask));
      if (got.notify_global !== x.notify_global)
        report($sformatf("notify_global %b, expected %b", got.notify_global, x.notify_global));
      if (got.notify_count !== x.notify_count)
        report($sformatf("notify_count %h, expected %h", got.notify_count, x.notify_count));
      if (got.error_code !== x.error_code)
        report($sformatf("error_code %0d, expected %0d", got.error_code, x.error_code));
      checked++;
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        opcode_i = '0;
  logic [IdxW-1:0]   slot_idx_i = '0;
  logic              glob_sel_i = 1'b0;
  logic [CountW-1:0] arrival_count_i = '0;
  logic [WidW-1:0]   warp_id_i = '0;
  logic              sync_flag_i = 1'b0;
  logic [PhaseW-1:0] expected_phase_i = '0;
  logic [WarpW-1:0]  active_mask_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PhaseW-1:0] phase_value_o;
  logic              must_wait_o;
  logic [WarpW-1:0]  resume_mask_o;
  logic              notify_global_o;
  logic [CountW-1:0] notify_count_o;
  logic [ErrW-1:0]   error_code_o;

  barrier_scoreboard sb;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned hot_target[4];
  req_t directed_q[$];

  warp_barrier_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .slot_idx_i      (slot_idx_i),
    .glob_sel_i      (glob_sel_i),
    .arrival_count_i (arrival_count_i),
    .warp_id_i       (warp_id_i),
    .sync_flag_i     (sync_flag_i),
    .expected_phase_i(expected_phase_i),
    .active_mask_i   (active_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .phase_value_o   (phase_value_o),
    .must_wait_o     (must_wait_o),
    .resume_mask_o   (resume_mask_o),
    .notify_global_o (notify_global_o),
    .notify_count_o  (notify_count_o),
    .error_code_o    (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t mk(logic [2:0] op, int idx, bit glob, int cnt, int wid, bit sync,
                              int exph, int act);
    req_t r;
    r.opcode = op;
    r.slot_idx = IdxW'(idx);
    r.glob_sel = glob;
    r.arrival_count = CountW'(cnt);
    r.warp_id = WidW'(wid);
    r.sync_flag = sync;
    r.expected_phase = PhaseW'(exph);
    r.active_mask = WarpW'(act);
    return r;
  endfunction

  function automatic int sender_gap();
    return tx_calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    logic [WarpW-1:0] wbit;
    if ($urandom_range(0, 9) < 8) r.slot_idx = IdxW'($urandom_range(0, 3));
    else r.slot_idx = IdxW'($urandom_range(0, 31));
    r.glob_sel = ($urandom_range(0, 2) == 0);
    r.warp_id = WidW'($urandom_range(0, 7));
    r.sync_flag = ($urandom_range(0, 3) != 0);
    wbit = WarpW'(1) << r.warp_id;
    case ($urandom_range(0, 3))
      0: r.active_mask = WarpW'($urandom_range(0, 255));
      1: r.active_mask = wbit;
      2: r.active_mask = wbit | (WarpW'(1) << $urandom_range(0, 7));
      default: r.active_mask = '1;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 7) r.arrival_count = CountW'(hot_target[r.slot_idx[1:0]]);
    else if (pick == 7) r.arrival_count = '0;
    else r.arrival_count = CountW'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) r.expected_phase = sb.phase_of(int'(r.slot_idx));
    else r.expected_phase = PhaseW'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 40) r.opcode = OP_ARRIVE;
    else if (pick < 60) r.opcode = OP_WAIT;
    else if (pick < 68) r.opcode = OP_READ_PHASE;
    else if (pick < 73) r.opcode = OP_GLOBAL_RES;
    else if (pick < 84) r.opcode = OP_EV_ATTACH;
    else if (pick < 97) r.opcode = OP_EV_RELEASE;
    else if ($urandom_range(0, 1) == 1) r.opcode = OpUnusedHi;
    else r.opcode = OpUnusedLo;
    return r;
  endfunction

  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= r.opcode;
    slot_idx_i       <= r.slot_idx;
    glob_sel_i       <= r.glob_sel;
    arrival_count_i  <= r.arrival_count;
    warp_id_i        <= r.warp_id;
    sync_flag_i      <= r.sync_flag;
    expected_phase_i <= r.expected_phase;
    active_mask_i    <= r.active_mask;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    res_t got;
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.phase_value = phase_value_o;
      got.must_wait = must_wait_o;
      got.resume_mask = resume_mask_o;
      got.notify_global = notify_global_o;
      got.notify_count = notify_count_o;
      got.error_code = err_e'(error_code_o);
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    sb = new();
    directed_q.push_back(mk(OP_READ_PHASE, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(OP_ARRIVE, 1, 0, 0, 0, 1, 0, 'hff));
    directed_q.push_back(mk(OP_EV_RELEASE, 1, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(OP_ARRIVE, 2, 0, 1, 7, 1, 0, 'h80));
    directed_q.push_back(mk(OP_WAIT, 2, 0, 0, 0, 0, 1, 'hff));
    directed_q.push_back(mk(OP_WAIT, 2, 0, 0, 1, 0, 0, 'hff));
    directed_q.push_back(mk(OP_GLOBAL_RES, 2, 0, 0, 0, 0, 0, 'hff));
    directed_q.push_back(mk(OP_ARRIVE, 3, 1, 0, 0, 0, 0, 'h01));
    directed_q.push_back(mk(OP_ARRIVE, 4, 1, 255, 5, 0, 0, 'h30));
    directed_q.push_back(mk(OP_ARRIVE, 4, 1, 200, 4, 0, 0, 'h30));
    directed_q.push_back(mk(OP_EV_ATTACH, 5, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(OP_ARRIVE, 5, 0, 1, 3, 1, 0, 'h08));
    directed_q.push_back(mk(OP_EV_RELEASE, 5, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(OP_EV_ATTACH, 6, 1, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(OP_ARRIVE, 6, 1, 9, 1, 0, 0, 'h02));
    directed_q.push_back(mk(OP_EV_RELEASE, 6, 1, 0, 0, 0, 0, 'h02));
    directed_q.push_back(mk(OP_ARRIVE, 7, 0, 255, 6, 0, 'hffff, 'h40));
    directed_q.push_back(mk(OP_WAIT, 7, 0, 255, 2, 1, 'hffff, 'hff));
    directed_q.push_back(mk(OpUnusedLo, 8, 1, 255, 7, 1, 'hffff, 'hff));
    directed_q.push_back(mk(OpUnusedHi, 31, 1, 255, 7, 1, 'hffff, 'hff));
    for (int w = 0; w < 3; w++) directed_q.push_back(mk(OP_ARRIVE, 9, 0, 3, w, 1, 0, 'h07));
    directed_q.push_back(mk(OP_ARRIVE, 10, 1, 250, 0, 0, 0, 'hff));
    directed_q.push_back(mk(OP_ARRIVE, 10, 0, 3, 1, 1, 0, 'hff));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_request(directed_q[i], sender_gap());
    wait_drained();

    // Fill one entry with events past the limit, then release a few of them.
    tx_calm = 1'b1;
    for (int i = 0; i < 256; i++) begin
      send_request(mk(OP_EV_ATTACH, FloodEntry, $urandom_range(0, 1), 0, 0, 0, 0, 0), 0);
    end
    for (int i = 0; i < 4; i++) begin
      send_request(mk(OP_EV_RELEASE, FloodEntry, $urandom_range(0, 1), 0, 0, 0, 0,
                      $urandom_range(0, 255)), $urandom_range(0, 2));
    end
    tx_calm = 1'b0;
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        foreach (hot_target[k]) hot_target[k] = $urandom_range(1, 4);
      end
      tx_calm = (n >= 60 && n < 120) || (n >= 200 && n < 260);
      rx_calm = (n >= 300 && n < 360);
      if (n == 200) hold_req = 1'b1;
      if (n == 380) wait_drained();
      send_request(random_request(), sender_gap());
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d transactions: directed corner cases, an event overflow flood",
             sb.checked);
    $display("and random traffic with stalls (%0d resumes, %0d notifies, %0d errors).",
             sb.resumes, sb.notifies, sb.faults);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> warp_barrier_table.f
rtl/core/wbt_pkg.sv
rtl/core/wbt_ram.sv
rtl/core/warp_barrier_table.sv
verif/tb_warp_barrier_table.sv
